[rtl/adbe_pkg.sv]
// Shared types and constants for the audio DAC bitstream encoder.
// No dependencies; every rtl file references this package by scoped names.
package adbe_pkg;

    localparam int LEVEL_W              = 16;
    localparam int WORD_W               = 32;
    localparam int RESID_W              = 8;
    localparam int ACC_BITS             = 16;
    localparam int PDM_WORDS_PER_SAMPLE = 2;

    // At most four PDM words per sample, at least one.
    localparam int MAX_STEPS = 4;
    localparam int PDM_COUNT = (PDM_WORDS_PER_SAMPLE > MAX_STEPS) ? MAX_STEPS :
                               ((PDM_WORDS_PER_SAMPLE < 1) ? 1 : PDM_WORDS_PER_SAMPLE);
    localparam int DAC_CODES = 4;
    localparam int STEP_W    = $clog2(MAX_STEPS);

    localparam logic [LEVEL_W-1:0] SIGN_FLIP = 16'h8000;
    localparam logic [LEVEL_W-1:0] MIDSCALE  = 16'h8000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hffff;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration port: word index taken from paddr[2]
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_OUTPUT_MODE = 1'b0;

    typedef enum logic [0:0] {
        MODE_PDM = 1'b0,
        MODE_DAC = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] prev;
    } cmd_t;

endpackage

[rtl/adbe_front.sv]
// Front end: takes samples, offsets them to unsigned levels and builds commands.
// Depends on adbe_pkg.
module adbe_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [adbe_pkg::LEVEL_W-1:0]   sample,
    input  adbe_pkg::mode_t                mode,
    input  logic                           fifo_full,
    output logic                           accept,
    output adbe_pkg::cmd_t                 cmd
);

    logic [adbe_pkg::LEVEL_W-1:0] prev_level_reg;
    logic [adbe_pkg::LEVEL_W-1:0] prev_level_next;
    logic [adbe_pkg::LEVEL_W-1:0] level;

    always_comb
    begin
        accept          = push && !fifo_full;
        level           = sample ^ adbe_pkg::SIGN_FLIP;
        cmd.mode        = mode;
        cmd.level       = level;
        cmd.prev        = prev_level_reg;
        prev_level_next = accept ? level : prev_level_reg;
    end

    // previous level follows every sample in both modes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= adbe_pkg::MIDSCALE;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
        end
    end

endmodule

[rtl/adbe_cmd_fifo.sv]
// Short command queue between front and back.
// Depends on adbe_pkg.
module adbe_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  adbe_pkg::cmd_t  wr_data,
    input  logic            rd_en,
    output adbe_pkg::cmd_t  rd_data,
    output logic            full,
    output logic            empty
);

    adbe_pkg::cmd_t mem_reg [adbe_pkg::FIFO_DEPTH];

    logic [adbe_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [adbe_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [adbe_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    function automatic logic [adbe_pkg::FIFO_PTR_W-1:0] ptr_inc(
        input logic [adbe_pkg::FIFO_PTR_W-1:0] p);
        logic [adbe_pkg::FIFO_PTR_W-1:0] r;
        if (p == adbe_pkg::FIFO_PTR_W'(adbe_pkg::FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        full        = (count_reg == adbe_pkg::FIFO_CNT_W'(adbe_pkg::FIFO_DEPTH));
        empty       = (count_reg == '0);
        rd_data     = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/adbe_back.sv]
// Back end: runs commands, one PDM word or DAC code per unstalled cycle, into out_word_reg.
// Depends on adbe_pkg.
module adbe_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  adbe_pkg::cmd_t               cmd,
    input  logic                         cmd_empty,
    output logic                         cmd_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [adbe_pkg::WORD_W-1:0]  out_word,
    output logic                         last
);

    localparam int MUL_W = adbe_pkg::LEVEL_W + $clog2(adbe_pkg::WORD_W) + 1;
    localparam int SUM_W = ((adbe_pkg::ACC_BITS > MUL_W) ? adbe_pkg::ACC_BITS : MUL_W) + 1;
    localparam int INT_W = adbe_pkg::LEVEL_W + 3;

    logic [adbe_pkg::ACC_BITS-1:0] acc_reg, acc_next;
    logic [adbe_pkg::RESID_W-1:0]  resid_reg, resid_next;
    logic [adbe_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    logic [adbe_pkg::WORD_W-1:0]   out_word_reg, out_word_next;
    logic                          last_reg, last_next;

    logic                          out_ready;
    logic                          fire;
    logic                          is_last;
    logic [adbe_pkg::WORD_W-1:0]   pdm_word;
    logic [adbe_pkg::ACC_BITS-1:0] pdm_acc;
    logic [SUM_W-1:0]              base;
    logic [SUM_W-1:0]              carry_sum;
    logic [INT_W-1:0]              interp_sum;
    logic [adbe_pkg::LEVEL_W-1:0]  interp;
    logic [adbe_pkg::LEVEL_W:0]    fb_sum;
    logic [adbe_pkg::LEVEL_W-1:0]  sat;
    logic [2:0]                    w_cur;
    logic [2:0]                    w_prev;
    logic [adbe_pkg::WORD_W-1:0]   dac_word;

    // PDM word: the accumulator after i additions is acc + i*level, so each of
    // the 32 carries is found independently from its own partial sum.
    always_comb
    begin
        pdm_word = '0;
        for (int i = 0; i < adbe_pkg::WORD_W; i++)
        begin
            base      = SUM_W'(acc_reg) + SUM_W'(i) * SUM_W'(cmd.level);
            carry_sum = SUM_W'(base[adbe_pkg::ACC_BITS-1:0]) + SUM_W'(cmd.level);
            pdm_word[adbe_pkg::WORD_W-1-i] = carry_sum[adbe_pkg::ACC_BITS];
        end
        base    = SUM_W'(acc_reg) + SUM_W'(adbe_pkg::WORD_W) * SUM_W'(cmd.level);
        pdm_acc = base[adbe_pkg::ACC_BITS-1:0];
    end

    // DAC code: weights (4-w, w) with w = step+1 give the four interpolation points
    always_comb
    begin
        w_cur      = 3'(step_reg) + 3'd1;
        w_prev     = 3'd4 - w_cur;
        interp_sum = INT_W'(cmd.prev) * INT_W'(w_prev) + INT_W'(cmd.level) * INT_W'(w_cur);
        interp     = interp_sum[adbe_pkg::LEVEL_W+1:2];
        fb_sum     = (adbe_pkg::LEVEL_W+1)'(interp) + (adbe_pkg::LEVEL_W+1)'(resid_reg);
        sat        = fb_sum[adbe_pkg::LEVEL_W] ? adbe_pkg::LEVEL_MAX
                                               : fb_sum[adbe_pkg::LEVEL_W-1:0];
        dac_word   = adbe_pkg::WORD_W'({sat[adbe_pkg::LEVEL_W-1:adbe_pkg::RESID_W],
                                        {adbe_pkg::RESID_W{1'b0}}});
    end

    always_comb
    begin
        out_ready      = !out_valid_reg || pop;
        fire           = !cmd_empty && out_ready;
        acc_next       = acc_reg;
        resid_next     = resid_reg;
        out_word_next  = out_word_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !pop;

        unique case (cmd.mode)
            adbe_pkg::MODE_PDM:
                is_last = (step_reg == adbe_pkg::STEP_W'(adbe_pkg::PDM_COUNT - 1));
            adbe_pkg::MODE_DAC:
                is_last = (step_reg == adbe_pkg::STEP_W'(adbe_pkg::DAC_CODES - 1));
            default:
                is_last = 1'b1;
        endcase

        cmd_pop   = fire && is_last;
        step_next = step_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            last_next      = is_last;
            step_next      = is_last ? '0 : step_reg + 1'b1;
            if (cmd.mode == adbe_pkg::MODE_PDM)
            begin
                out_word_next = pdm_word;
                acc_next      = pdm_acc;
            end
            else
            begin
                out_word_next = dac_word;
                resid_next    = sat[adbe_pkg::RESID_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            resid_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            resid_reg     <= resid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        last_reg     <= last_next;
    end

    assign empty    = !out_valid_reg;
    assign out_word = out_word_reg;
    assign last     = last_reg;

endmodule

[rtl/audio_dac_bitstream_encoder.sv]
// Top level of the audio DAC bitstream encoder: config register, front, queue, back.
// Depends on adbe_pkg, adbe_front, adbe_cmd_fifo, adbe_back.
//
//  channel   direction  handshake          payload
//  sample    in         push / full        sample[15:0] signed
//  result    out        pop / empty        out_word[31:0], last
//  config    in         psel/penable/...   output_mode at paddr 0 (bit 0)
//
// Each sample yields PDM_COUNT result words (two) in PDM mode and four in DAC mode; the
// front accepts one sample per cycle until the two-entry command queue fills. An
// accepted sample is written into the command queue, and its first result is then
// registered in the back end's output register before it reaches the ports.
// Reset is asynchronous, active low, and clears mode, accumulator, residual and queues.
// A stalled pop holds the output register; the back end then stops and the queue fills.
module audio_dac_bitstream_encoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [adbe_pkg::LEVEL_W-1:0]  sample,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [adbe_pkg::WORD_W-1:0]          out_word,
    output logic                                 last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adbe_pkg::ADDR_W-1:0]          paddr,
    input  logic [adbe_pkg::DATA_W-1:0]          pwdata,
    output logic [adbe_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    adbe_pkg::mode_t mode_reg, mode_next;
    adbe_pkg::cmd_t  front_cmd;
    adbe_pkg::cmd_t  back_cmd;
    logic            accept;
    logic            fifo_empty;
    logic            fifo_pop;
    logic            cfg_wr;

    always_comb
    begin
        pready    = 1'b1;
        cfg_wr    = psel && penable && pwrite && pready;
        mode_next = mode_reg;
        if (cfg_wr && paddr[2] == adbe_pkg::REG_OUTPUT_MODE)
            mode_next = adbe_pkg::mode_t'(pwdata[0]);
        prdata = '0;
        if (paddr[2] == adbe_pkg::REG_OUTPUT_MODE)
            prdata = adbe_pkg::DATA_W'(mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= adbe_pkg::MODE_PDM;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    adbe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .mode      (mode_reg),
        .fifo_full (full),
        .accept    (accept),
        .cmd       (front_cmd)
    );

    adbe_cmd_fifo u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .rd_en   (fifo_pop),
        .rd_data (back_cmd),
        .full    (full),
        .empty   (fifo_empty)
    );

    adbe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (fifo_empty),
        .cmd_pop   (fifo_pop),
        .pop       (pop),
        .empty     (empty),
        .out_word  (out_word),
        .last      (last)
    );

endmodule

[rtl/adbe_checker.sv]
// Port-level checks for the audio DAC bitstream encoder, bound to the top level.
// Depends on adbe_pkg and audio_dac_bitstream_encoder.
module adbe_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic signed [adbe_pkg::LEVEL_W-1:0]  sample,
    input  logic                                 pop,
    input  logic                                 empty,
    input  logic [adbe_pkg::WORD_W-1:0]          out_word,
    input  logic                                 last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adbe_pkg::ADDR_W-1:0]          paddr,
    input  logic [adbe_pkg::DATA_W-1:0]          pwdata,
    input  logic [adbe_pkg::DATA_W-1:0]          prdata,
    input  logic                                 pready
);

    // a waiting result stays put until its transfer
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_word) && $stable(last))
        else $error("result changed or vanished before its transfer");

    // no result can be waiting right after reset
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

    // DAC codes carry only the upper byte of the level plus residual in bits 15:8
    a_dac_format: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && paddr[2] == adbe_pkg::REG_OUTPUT_MODE && prdata[0]
        |-> out_word[7:0] == '0 && out_word[31:16] == '0)
        else $error("DAC code word has bits outside 15:8");

    // config read port: one-bit register, always ready
    a_cfg_port: assert property (@(posedge clk) disable iff (!rst_n)
        pready && prdata[adbe_pkg::DATA_W-1:1] == '0)
        else $error("config port not ready or read data too wide");

    // the command queue can only fill behind a waiting result
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input full while no result is waiting");

endmodule

bind audio_dac_bitstream_encoder adbe_checker u_adbe_checker (.*);

[verif/audio_dac_bitstream_encoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for audio_dac_bitstream_encoder: PDM and DAC-code modes.
// Depends on adbe_pkg and the encoder RTL; a scoreboard class predicts every result word.
module audio_dac_bitstream_encoder_tb;

    import adbe_pkg::*;

    localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'(4 * REG_OUTPUT_MODE);
    localparam int                SPARE_REG  = 1;
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * SPARE_REG);
    localparam int                PHASES     = 10;
    localparam int                PHASE_LEN  = 25;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } coded_word_t;

    class bitstream_scoreboard;
        mode_t               mode;
        logic [ACC_BITS-1:0] pdm_acc;
        logic [LEVEL_W-1:0]  prior_level;
        logic [RESID_W-1:0]  residual;
        coded_word_t         expected_words[$];
        int                  errors;

        function new();
            mode        = MODE_PDM;
            pdm_acc     = '0;
            prior_level = MIDSCALE;
            residual    = '0;
            errors      = 0;
        endfunction

        function void set_mode(logic v);
            mode = mode_t'(v);
        endfunction

        function int pending_count();
            return expected_words.size();
        endfunction

        function void note_mismatch(string what, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] act_v);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s mismatch: expected %h, got %h",
                         $time, what, exp_v, act_v);
        endfunction

        function void expect_word(logic [WORD_W-1:0] w, logic is_last);
            coded_word_t r;
            r.word = w;
            r.last = is_last;
            expected_words.push_back(r);
        endfunction

        // error-feedback quantizer: sum saturates, upper byte is the code
        function logic [WORD_W-1:0] quantize_step(int unsigned interp);
            int unsigned total;
            total = interp + residual;
            if (total > 32'hffff)
                total = 32'hffff;
            residual = RESID_W'(total & 32'hff);
            return total & 32'hff00;
        endfunction

        function void note_sample(logic [LEVEL_W-1:0] raw);
            logic [LEVEL_W-1:0] level;
            int unsigned        lv;
            int unsigned        pv;
            int unsigned        sum;
            logic [WORD_W-1:0]  w;
            level = raw ^ SIGN_FLIP;
            lv    = level;
            pv    = prior_level;
            if (mode == MODE_PDM)
            begin
                for (int k = 0; k < PDM_COUNT; k++)
                begin
                    w = '0;
                    for (int i = 0; i < 32; i++)
                    begin
                        sum     = pdm_acc + lv;
                        w       = {w[WORD_W-2:0], 1'((sum >> ACC_BITS) & 1)};
                        pdm_acc = ACC_BITS'(sum);
                    end
                    expect_word(w, k == PDM_COUNT - 1);
                end
            end
            else
            begin
                expect_word(quantize_step((pv * 3 + lv) >> 2), 1'b0);
                expect_word(quantize_step((pv + lv) >> 1), 1'b0);
                expect_word(quantize_step((pv + lv * 3) >> 2), 1'b0);
                expect_word(quantize_step(lv), 1'b1);
            end
            prior_level = level;
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic last_flag);
            coded_word_t e;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result %h with nothing expected", $time, word);
                return;
            end
            e = expected_words.pop_front();
            if (word !== e.word)
                note_mismatch("out_word", e.word, word);
            if (last_flag !== e.last)
                note_mismatch("last", WORD_W'(e.last), WORD_W'(last_flag));
        endfunction
    endclass

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                push    = 1'b0;
    logic [LEVEL_W-1:0]  sample  = '0;
    logic                pop     = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic                full;
    logic                empty;
    logic [WORD_W-1:0]   out_word;
    logic                last;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [15:0]         pop_pattern = 16'hffff;
    logic [3:0]          stall_idx   = '0;

    bitstream_scoreboard sb = new();

    audio_dac_bitstream_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .pop      (pop),
        .empty    (empty),
        .out_word (out_word),
        .last     (last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        stall_idx <= stall_idx + 1'b1;
        pop       <= pop_pattern[stall_idx];
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_sample(sample);
            if (pop && !empty)
                sb.check_result(out_word, last);
        end
    end

    // All driving tasks start right after a rising edge.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == MODE_ADDR)
            sb.set_mode(data[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_mode_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== logic'(sb.mode))
            sb.note_mismatch("output_mode readback", WORD_W'(sb.mode), WORD_W'(prdata[0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [LEVEL_W-1:0] s, input int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        do @(posedge clk); while (full);
    endtask

    // stop sending and let every expected word drain
    task automatic drain();
        push <= 1'b0;
        // wait on the clock so the last accepted sample is already on the scoreboard
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic pick_stall_pattern();
        case ($urandom_range(0, 2))
            0:       pop_pattern <= 16'hffff;
            1:       pop_pattern <= 16'($urandom_range(1, 16'hffff));
            default: pop_pattern <= 16'h1 << $urandom_range(0, 15);
        endcase
    endtask

    function automatic logic [LEVEL_W-1:0] pick_sample(logic [LEVEL_W-1:0] prior);
        int kind;
        int delta;
        kind  = $urandom_range(0, 9);
        delta = $urandom_range(0, 2047);
        delta = delta - 1024;
        if (kind == 0)
            return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        else if (kind == 1)
            return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
        else if (kind < 6)
            return 16'($urandom);
        // slowly moving audio-like signal
        return prior + 16'(delta);
    endfunction

    initial
    begin
        logic [LEVEL_W-1:0] prior;
        int                 burst_left;
        int                 gap;
        bit                 use_gaps;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // PDM mode straight out of reset
        check_mode_readback();
        pop_pattern <= 16'hb6db;
        send_sample(16'h8000, 0);
        send_sample(16'h7fff, 0);
        send_sample(16'h0000, 0);
        send_sample(16'hffff, 2);
        send_sample(16'h0001, 0);
        send_sample(16'h5555, 1);
        send_sample(16'haaaa, 0);
        drain();

        // write past the register file is dropped
        apb_write(SPARE_ADDR, 32'hffff_ffff);
        check_mode_readback();
        apb_write(MODE_ADDR, DATA_W'(MODE_DAC));
        check_mode_readback();

        // full scale held: interpolation plus residual saturates
        pop_pattern <= 16'h7777;
        send_sample(16'h7fff, 0);
        send_sample(16'h7fff, 0);
        send_sample(16'h7fff, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h7fff, 3);
        send_sample(16'h0000, 0);
        send_sample(16'hffff, 0);
        send_sample(16'h1234, 0);
        drain();

        // back to PDM; upper data bits set but ignored
        apb_write(MODE_ADDR, 32'hffff_fffe);
        check_mode_readback();
        send_sample(16'h7fff, 0);
        send_sample(16'h8000, 0);
        drain();

        prior = 16'h0000;
        for (int p = 0; p < PHASES; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                apb_write(SPARE_ADDR, $urandom);
            apb_write(MODE_ADDR, ($urandom & 32'hffff_fffe) | DATA_W'($urandom_range(0, 1)));
            check_mode_readback();
            pick_stall_pattern();
            use_gaps   = $urandom_range(0, 3) != 0;
            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                gap = 0;
                if (use_gaps)
                begin
                    if (burst_left == 0)
                    begin
                        gap        = $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 16);
                    end
                    burst_left--;
                end
                prior = pick_sample(prior);
                send_sample(prior, gap);
                if ($urandom_range(0, 15) == 0)
                    pick_stall_pattern();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("audio_dac_bitstream_encoder_tb passed");
        else
            $display("audio_dac_bitstream_encoder_tb failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("audio_dac_bitstream_encoder_tb failed");
        $finish;
    end

endmodule

[audio_dac_bitstream_encoder.f]
rtl/adbe_pkg.sv
rtl/adbe_front.sv
rtl/adbe_cmd_fifo.sv
rtl/adbe_back.sv
rtl/audio_dac_bitstream_encoder.sv
rtl/adbe_checker.sv
verif/audio_dac_bitstream_encoder_tb.sv
